>>> src/fpfa_pkg.sv
package fpfa_pkg;

  localparam int PartitionsDef = 8;
  localparam int SizeBitsDef   = 16;

  // Fixed field widths of the item and result words
  localparam int SizeFieldW = 16;
  localparam int IdxFieldW  = 3;
  localparam int PidW       = 8;
  localparam int TotalW     = 19;

  // Configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CfgFitMode    = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgPartsInUse = 4'd1;
  localparam logic [3:0] PartsInUseReset = 4'd8;

  typedef enum logic [1:0] {
    FitFirst = 2'd0,
    FitBest  = 2'd1,
    FitWorst = 2'd2
  } fit_mode_e;

  typedef enum logic {
    FuncLoad  = 1'b0,
    FuncPlace = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoadRd,
    StLoadWr,
    StScan,
    StDrain,
    StCommit
  } state_e;

  typedef struct packed {
    logic                  func;
    logic [IdxFieldW-1:0]  partition_index;
    logic [SizeFieldW-1:0] size_value;
  } in_word_t;

  typedef struct packed {
    logic                  placed;
    logic [IdxFieldW-1:0]  chosen_partition;
    logic [SizeFieldW-1:0] leftover;
    logic [PidW-1:0]       process_id;
    logic [TotalW-1:0]     total_leftover;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load_commit;
    logic scan_issue;
    logic place_commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_place;
    logic lim_zero;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

>>> src/fpfa_ctrl.sv
module fpfa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fpfa_pkg::stat_t stat_i,
  output fpfa_pkg::cmd_t  cmd_o
);
  import fpfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!stat_i.in_is_place) begin
            state_d = StLoadRd;
          end else if (stat_i.lim_zero) begin
            state_d = StCommit;
          end else begin
            state_d = StScan;
          end
        end
      end
      StLoadRd: begin
        state_d = StLoadWr;
      end
      StLoadWr: begin
        if (stat_i.out_free) begin
          cmd_o.load_commit = 1'b1;
          state_d           = StIdle;
        end
      end
      StScan: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StCommit;
      end
      StCommit: begin
        if (stat_i.out_free) begin
          cmd_o.place_commit = 1'b1;
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

>>> src/fpfa_datapath.sv
module fpfa_datapath #(
  parameter int PARTITIONS = fpfa_pkg::PartitionsDef,
  parameter int SIZE_BITS  = fpfa_pkg::SizeBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [fpfa_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fpfa_pkg::CfgDataW-1:0]    cfg_data_i,
  input  fpfa_pkg::in_word_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output fpfa_pkg::out_word_t              out_data_o,
  input  fpfa_pkg::cmd_t                   cmd_i,
  output fpfa_pkg::stat_t                  stat_o
);
  import fpfa_pkg::*;

  localparam int AW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CW = $clog2(PARTITIONS + 1);
  localparam int SW = (SIZE_BITS < SizeFieldW) ? SIZE_BITS : SizeFieldW;

  // Configuration
  logic [1:0] fit_mode_q;
  logic [3:0] parts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= FitFirst;
      parts_q    <= PartsInUseReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFitMode:    fit_mode_q <= cfg_data_i[1:0];
        CfgPartsInUse: parts_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Clamp the search count to the number of partitions
  logic [CW-1:0] lim;
  always_comb begin
    if ({28'd0, parts_q} > 32'(PARTITIONS)) begin
      lim = CW'(PARTITIONS);
    end else begin
      lim = CW'(parts_q);
    end
  end

  // Item registers
  logic [IdxFieldW-1:0] idx_q;
  logic [SW-1:0]        psize_q;
  logic [CW-1:0]        lim_q, sc_q;
  logic [AW-1:0]        ld_addr;
  logic                 ld_in_range;

  assign ld_addr     = AW'(idx_q);
  assign ld_in_range = ({29'd0, idx_q} < 32'(PARTITIONS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q   <= in_data_i.partition_index;
      psize_q <= in_data_i.size_value[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q  <= '0;
      lim_q <= '0;
    end else if (cmd_i.accept) begin
      sc_q  <= '0;
      lim_q <= lim;
    end else if (cmd_i.scan_issue) begin
      sc_q <= sc_q + CW'(1);
    end
  end

  // Partition stores
  logic [SW-1:0] size_mem [PARTITIONS];
  logic [SW-1:0] lo_mem   [PARTITIONS];
  logic [SW-1:0] size_rd_q, lo_rd_q;
  logic [PARTITIONS-1:0] taken_q;

  logic          found_q, eval_v_q;
  logic [AW-1:0] eval_idx_q, best_idx_q;
  logic [SW-1:0] best_diff_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_commit && ld_in_range) begin
      size_mem[ld_addr] <= psize_q;
    end
    size_rd_q <= size_mem[sc_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.place_commit && found_q) begin
      lo_mem[best_idx_q] <= best_diff_q;
    end
    lo_rd_q <= lo_mem[ld_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (cmd_i.load_commit && ld_in_range) begin
      taken_q[ld_addr] <= 1'b0;
    end else if (cmd_i.place_commit && found_q) begin
      taken_q[best_idx_q] <= 1'b1;
    end
  end

  // Scan evaluation of each partition, in the cycle after its store is read
  logic [SW-1:0] diff;
  logic          cand, take;

  assign diff = size_rd_q - psize_q;
  assign cand = eval_v_q && !taken_q[eval_idx_q] && (size_rd_q >= psize_q);
  assign take = cand && (!found_q ||
                         ((fit_mode_q == FitBest)  && (diff < best_diff_q)) ||
                         ((fit_mode_q == FitWorst) && (diff > best_diff_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_v_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      eval_v_q <= cmd_i.scan_issue;
      if (cmd_i.accept) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q <= sc_q[AW-1:0];
    if (take) begin
      best_idx_q  <= eval_idx_q;
      best_diff_q <= diff;
    end
  end

  // Running totals
  logic [TotalW-1:0] total_q, total_d;
  logic [PidW-1:0]   pid_q;

  always_comb begin
    total_d = total_q;
    if (cmd_i.load_commit && ld_in_range && taken_q[ld_addr]) begin
      total_d = total_q - TotalW'(lo_rd_q);
    end else if (cmd_i.place_commit && found_q) begin
      total_d = total_q + TotalW'(best_diff_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      pid_q   <= '0;
    end else begin
      total_q <= total_d;
      if (cmd_i.place_commit) begin
        pid_q <= pid_q + PidW'(1);
      end
    end
  end

  // Output register
  logic      out_valid_q;
  out_word_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_commit || cmd_i.place_commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_commit) begin
      out_data_q <= '{placed: 1'b0, chosen_partition: '0, leftover: '0,
                      process_id: '0, total_leftover: total_d};
    end else if (cmd_i.place_commit) begin
      out_data_q.placed           <= found_q;
      out_data_q.chosen_partition <= found_q ? IdxFieldW'(best_idx_q) : '0;
      out_data_q.leftover         <= found_q ? SizeFieldW'(best_diff_q) : '0;
      out_data_q.process_id       <= pid_q;
      out_data_q.total_leftover   <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.in_is_place = (in_data_i.func == FuncPlace);
  assign stat_o.lim_zero    = (lim == '0);
  assign stat_o.scan_last   = (sc_q == (lim_q - CW'(1)));
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

endmodule

>>> src/fixed_partition_fit_allocator_unit.sv
// Channel  Direction  Handshake                 Word
// cfg      in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_ready_o     in_data_i  (func, index, size)
// out      out        out_valid_o/out_ready_i   out_data_o (placed .. total)
//
// A load word passes the read and write states and then commits its result; a
// place word scans N partitions, one partition a cycle, drains and commits, N
// being the clamped count. A zero count skips the scan and goes straight to
// the commit. The next word is taken once the commit has returned to idle.
// Reset sets first fit and a count of eight and clears the occupancy marks,
// the running total and the process number; no clearing pass runs.
// A new word is taken while a result waits; a stalled output holds the commit.
module fixed_partition_fit_allocator_unit #(
  parameter int PARTITIONS = fpfa_pkg::PartitionsDef,
  parameter int SIZE_BITS  = fpfa_pkg::SizeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fpfa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fpfa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fpfa_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fpfa_pkg::out_word_t           out_data_o
);
  import fpfa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Config writes must only land while idle; the block does not enforce it, so take them at once
  assign cfg_ready_o = 1'b1;

  // Sequence load and place words
  fpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold partition stores, scan compare, totals and the output register
  fpfa_datapath #(
    .PARTITIONS (PARTITIONS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

`ifndef SYNTHESIS
  // A word in flight blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after accept");

  // Every commit presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_commit || cmd.place_commit) |=> out_valid_o)
    else $error("commit without result");

  // Commands are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.load_commit, cmd.scan_issue, cmd.place_commit}))
    else $error("overlapping commands");

  // Commits only when the output register can take the word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_commit || cmd.place_commit) |-> (!out_valid_o || out_ready_i))
    else $error("commit overwrote a pending result");
`endif

endmodule
